/* sv/ep2q_pkg.sv */
// ----------------------------------------------------------------------------
// ep2q_pkg: shared types and constants for the pose to quaternion block
// Payload structs, stage enables, fixed-point constants and the quarter-wave
// sine table that is built at elaboration.
// ----------------------------------------------------------------------------
package ep2q_pkg;

  // Sine table geometry
  localparam int unsigned SINE_TABLE_ADDR_BITS = 10;
  localparam int unsigned TAB_N      = 1 << SINE_TABLE_ADDR_BITS;
  localparam int unsigned IDX_SHIFT  = 14 - SINE_TABLE_ADDR_BITS;
  localparam int unsigned IDX_HALF   = (1 << IDX_SHIFT) >> 1;

  // Pipeline depth, input transfer to output register
  localparam int unsigned NUM_STAGES = 6;

  // Fixed-point constants
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [32:0] PHASE_SCALE  = 33'sd41722;
  localparam logic signed [32:0] PHASE_RND    = 33'sd32768;
  localparam logic [15:0]        QUARTER_TURN = 16'h4000;
  localparam logic signed [15:0] Q14_ONE      = 16'sd16384;
  localparam logic signed [31:0] INT32_MIN    = 32'sh8000_0000;
  localparam logic signed [31:0] INT32_MAX    = 32'sh7FFF_FFFF;

  // Taylor series divisors (2n)(2n+1), n = 1..8
  localparam longint unsigned TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef logic [SINE_TABLE_ADDR_BITS:0] tab_idx_t;
  typedef logic [14:0]                   tab_val_t;
  typedef tab_val_t                      sin_tab_t [TAB_N+1];

  localparam tab_idx_t TAB_N_IDX = tab_idx_t'(TAB_N);

  typedef struct packed {
    logic signed [31:0] pos_north;
    logic signed [31:0] pos_east;
    logic signed [31:0] pos_down;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } pose_in_t;

  typedef struct packed {
    logic signed [31:0] frame_x;
    logic signed [31:0] frame_y;
    logic signed [31:0] frame_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } pose_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } frame_pos_t;

  // Load enables for the three sine/cosine stages
  typedef struct packed {
    logic phase;
    logic addr;
    logic read;
  } stage_en_t;

  // Build sin(k*(pi/2)/2^B) in Q1.14 from a Q30 Taylor series to x^17
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t          tab;
    longint unsigned   x;
    longint unsigned   term;
    longint            sum;
    for (int k = 0; k <= int'(TAB_N); k++) begin
      x    = (longint'(k) * HALF_PI_Q30) / TAB_N;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / TAYLOR_DIV[n-1];
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 32768) >>> 16;
      if (sum > 16384) begin
        sum = 16384;
      end
      tab[k] = tab_val_t'(sum);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

/* sv/ep2q_sincos.sv */
// ----------------------------------------------------------------------------
// ep2q_sincos: half-angle sine and cosine of one Q3.13 angle
// Three stages: half-angle phase, quadrant table address, table read with
// sign. Results are Q1.14.
// ----------------------------------------------------------------------------
module ep2q_sincos (
  input  logic                clk_i,
  input  ep2q_pkg::stage_en_t en_i,
  input  logic signed [15:0]  angle_i,
  output logic signed [15:0]  sin_o,
  output logic signed [15:0]  cos_o
);

  typedef struct packed {
    ep2q_pkg::tab_idx_t idx;
    logic               neg;
  } tab_addr_t;

  // Map a 16-bit phase to a quarter-wave table entry and a sign
  function automatic tab_addr_t tab_addr(input logic [15:0] p);
    logic [14:0]        rnd;
    logic [14:0]        shifted;
    ep2q_pkg::tab_idx_t i;
    tab_addr_t          a;
    rnd     = {1'b0, p[13:0]} + 15'(ep2q_pkg::IDX_HALF);
    shifted = rnd >> ep2q_pkg::IDX_SHIFT;
    i       = shifted[ep2q_pkg::SINE_TABLE_ADDR_BITS:0];
    if (i > ep2q_pkg::TAB_N_IDX) begin
      i = ep2q_pkg::TAB_N_IDX;
    end
    if (p[14]) begin
      i = ep2q_pkg::TAB_N_IDX - i;
    end
    a.idx = i;
    a.neg = p[15];
    return a;
  endfunction

  logic signed [32:0] phase_prod;
  logic signed [32:0] phase_sum;
  logic [15:0]        phase_d, phase_q;
  tab_addr_t          sin_addr_d, sin_addr_q;
  tab_addr_t          cos_addr_d, cos_addr_q;
  logic signed [15:0] sin_mag, cos_mag;
  logic signed [15:0] sin_d, sin_q;
  logic signed [15:0] cos_d, cos_q;

  // Half angle in units of 2^-16 turn, rounded
  assign phase_prod = $signed({{17{angle_i[15]}}, angle_i}) * ep2q_pkg::PHASE_SCALE;
  assign phase_sum  = phase_prod + ep2q_pkg::PHASE_RND;
  assign phase_d    = phase_sum[31:16];

  // Table addresses; cosine leads sine by a quarter turn
  assign sin_addr_d = tab_addr(phase_q);
  assign cos_addr_d = tab_addr(phase_q + ep2q_pkg::QUARTER_TURN);

  // Read table and apply sign
  assign sin_mag = $signed({1'b0, ep2q_pkg::SIN_TAB[sin_addr_q.idx]});
  assign cos_mag = $signed({1'b0, ep2q_pkg::SIN_TAB[cos_addr_q.idx]});
  assign sin_d   = sin_addr_q.neg ? -sin_mag : sin_mag;
  assign cos_d   = cos_addr_q.neg ? -cos_mag : cos_mag;

  // Stage registers, advance on their enables
  always_ff @(posedge clk_i) begin
    if (en_i.phase) begin
      phase_q <= phase_d;
    end
    if (en_i.addr) begin
      sin_addr_q <= sin_addr_d;
      cos_addr_q <= cos_addr_d;
    end
    if (en_i.read) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

/* sv/euler_pose_to_quaternion.sv */
// ----------------------------------------------------------------------------
// euler_pose_to_quaternion: NED vehicle pose to display frame pose
// Remaps position to x = east, y = north, z = -down (saturated) and turns
// roll, pitch and yaw into a remapped Q1.14 quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one pose (in_data_i) per
//   transfer; output channel out_valid_o/out_ready_i carries one frame pose
//   (out_data_o) per transfer. Every input transfer gives exactly one result.
//   Throughput is one pose per cycle while the receiver takes results; the
//   six-stage pipeline (phase multiply, table address, table read, pair
//   products, triple products, sum and round) registers each step in turn.
//   Each stage holds its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up: while the receiver stalls,
//   new poses are still taken until all six stages are full, then in_ready_o
//   drops. Nothing is lost or repeated across a stall.
//   Reset (rst_ni low) clears all valid bits; the pipeline is empty and ready
//   right after it. The sine table is a constant, so no fill is needed.
// ----------------------------------------------------------------------------
module euler_pose_to_quaternion (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ep2q_pkg::pose_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ep2q_pkg::pose_out_t out_data_o
);

  localparam int unsigned LAST = ep2q_pkg::NUM_STAGES - 1;
  localparam logic signed [16:0] Q_MAX     = 17'sd16384;
  localparam logic signed [16:0] Q_MIN     = -17'sd16384;
  localparam logic signed [44:0] ROUND_Q28 = 45'sd134217728;

  // Round a Q3.42 sum half up to Q1.14 and saturate to +-1.0
  function automatic logic signed [15:0] to_q14(input logic signed [44:0] s);
    logic signed [44:0] t;
    logic signed [16:0] r;
    logic signed [15:0] q;
    t = s + ROUND_Q28;
    r = $signed(t[44:28]);
    if (r > Q_MAX) begin
      q = ep2q_pkg::Q14_ONE;
    end else if (r < Q_MIN) begin
      q = -ep2q_pkg::Q14_ONE;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  function automatic logic signed [44:0] ext45(input logic signed [43:0] v);
    return $signed({v[43], v});
  endfunction

  // Stage valids and load enables
  logic [LAST:0]       valid_q;
  logic [LAST:0]       stage_en;
  ep2q_pkg::stage_en_t sc_en;

  always_comb begin
    stage_en[LAST] = !valid_q[LAST] || out_ready_i;
    for (int k = int'(LAST) - 1; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign in_ready_o = stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= int'(LAST); k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Sine and cosine of the three half angles, stages one to three
  assign sc_en.phase = stage_en[0];
  assign sc_en.addr  = stage_en[1];
  assign sc_en.read  = stage_en[2];

  logic signed [15:0] sr, cr, sp, cp, sy, cy;

  ep2q_sincos u_roll (
    .clk_i   (clk_i),
    .en_i    (sc_en),
    .angle_i (in_data_i.roll_angle),
    .sin_o   (sr),
    .cos_o   (cr)
  );

  ep2q_sincos u_pitch (
    .clk_i   (clk_i),
    .en_i    (sc_en),
    .angle_i (in_data_i.pitch_angle),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  ep2q_sincos u_yaw (
    .clk_i   (clk_i),
    .en_i    (sc_en),
    .angle_i (in_data_i.yaw_angle),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  // Position remap with z saturation, then carry along the pipeline
  ep2q_pkg::frame_pos_t pos_d;
  ep2q_pkg::frame_pos_t pos_q [LAST];

  always_comb begin
    pos_d.x = in_data_i.pos_east;
    pos_d.y = in_data_i.pos_north;
    if (in_data_i.pos_down == ep2q_pkg::INT32_MIN) begin
      pos_d.z = ep2q_pkg::INT32_MAX;
    end else begin
      pos_d.z = -in_data_i.pos_down;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      pos_q[0] <= pos_d;
    end
    for (int k = 1; k < int'(LAST); k++) begin
      if (stage_en[k]) begin
        pos_q[k] <= pos_q[k-1];
      end
    end
  end

  // Stage four: yaw-pitch pair products, carry roll terms
  logic signed [31:0] cysp_d, cycp_d, sysp_d, sycp_d;
  logic signed [31:0] cysp_q, cycp_q, sysp_q, sycp_q;
  logic signed [15:0] sr4_q, cr4_q;

  assign cysp_d = cy * sp;
  assign cycp_d = cy * cp;
  assign sysp_d = sy * sp;
  assign sycp_d = sy * cp;

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      cysp_q <= cysp_d;
      cycp_q <= cycp_d;
      sysp_q <= sysp_d;
      sycp_q <= sycp_d;
      sr4_q  <= sr;
      cr4_q  <= cr;
    end
  end

  // Stage five: triple products in Q3.42
  logic signed [47:0] cysp_cr, cysp_sr, cycp_cr, cycp_sr;
  logic signed [47:0] sysp_cr, sysp_sr, sycp_cr, sycp_sr;
  logic signed [43:0] cysp_cr_q, cysp_sr_q, cycp_cr_q, cycp_sr_q;
  logic signed [43:0] sysp_cr_q, sysp_sr_q, sycp_cr_q, sycp_sr_q;

  assign cysp_cr = cysp_q * cr4_q;
  assign cysp_sr = cysp_q * sr4_q;
  assign cycp_cr = cycp_q * cr4_q;
  assign cycp_sr = cycp_q * sr4_q;
  assign sysp_cr = sysp_q * cr4_q;
  assign sysp_sr = sysp_q * sr4_q;
  assign sycp_cr = sycp_q * cr4_q;
  assign sycp_sr = sycp_q * sr4_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      cysp_cr_q <= cysp_cr[43:0];
      cysp_sr_q <= cysp_sr[43:0];
      cycp_cr_q <= cycp_cr[43:0];
      cycp_sr_q <= cycp_sr[43:0];
      sysp_cr_q <= sysp_cr[43:0];
      sysp_sr_q <= sysp_sr[43:0];
      sycp_cr_q <= sycp_cr[43:0];
      sycp_sr_q <= sycp_sr[43:0];
    end
  end

  // Stage six: sum term pairs, round and saturate into the output register
  ep2q_pkg::pose_out_t out_d, out_q;

  always_comb begin
    out_d.frame_x = pos_q[LAST-1].x;
    out_d.frame_y = pos_q[LAST-1].y;
    out_d.frame_z = pos_q[LAST-1].z;
    out_d.quat_x  = to_q14(ext45(cysp_cr_q) + ext45(sycp_sr_q));
    out_d.quat_y  = to_q14(ext45(cycp_sr_q) - ext45(sysp_cr_q));
    out_d.quat_z  = to_q14(ext45(cysp_sr_q) - ext45(sycp_cr_q));
    out_d.quat_w  = to_q14(ext45(cycp_cr_q) + ext45(sysp_sr_q));
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[LAST]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q[LAST];
  assign out_data_o  = out_q;

endmodule

/* sv/ep2q_checker.sv */
// ----------------------------------------------------------------------------
// ep2q_checker: port-level checks for euler_pose_to_quaternion
// Watches the top-level ports for output hold, ready behavior and result
// ranges; attached to every instance by a bind.
// ----------------------------------------------------------------------------
module ep2q_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ep2q_pkg::pose_out_t out_data_o
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // Take input whenever the output register is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // Keep quaternion parts within +-1.0
  a_quat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.quat_x <= ep2q_pkg::Q14_ONE && out_data_o.quat_x >= -ep2q_pkg::Q14_ONE &&
      out_data_o.quat_y <= ep2q_pkg::Q14_ONE && out_data_o.quat_y >= -ep2q_pkg::Q14_ONE &&
      out_data_o.quat_z <= ep2q_pkg::Q14_ONE && out_data_o.quat_z >= -ep2q_pkg::Q14_ONE &&
      out_data_o.quat_w <= ep2q_pkg::Q14_ONE && out_data_o.quat_w >= -ep2q_pkg::Q14_ONE)
    else $error("quaternion part out of range");

  // Negated down never wraps to the most negative value
  a_z_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.frame_z != ep2q_pkg::INT32_MIN)
    else $error("frame z wrapped instead of saturating");

endmodule

bind euler_pose_to_quaternion ep2q_checker u_ep2q_checker (.*);

/* dv/pose_frame_checker.sv */
// ----------------------------------------------------------------------------
// pose_frame_checker: scoreboard for the pose to quaternion pipeline
// Watches both valid/ready channels. Each input transfer is turned into an
// expected frame pose by a bit-exact fixed-point model (own quarter-wave sine
// table, half-angle phase, rounded sums of triple products). Each output
// transfer is compared field by field against the oldest expected pose.
// ----------------------------------------------------------------------------
module pose_frame_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  ep2q_pkg::pose_in_t in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  ep2q_pkg::pose_out_t out_data_i,
  output int                 pending_o,
  output int                 fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  localparam int unsigned ADDR_BITS  = ep2q_pkg::SINE_TABLE_ADDR_BITS;
  localparam int unsigned STEPS      = 1 << ADDR_BITS;
  localparam int unsigned IDX_SHIFT  = 14 - ADDR_BITS;
  localparam int unsigned IDX_ROUND  = (1 << IDX_SHIFT) >> 1;
  localparam u64_t        HALF_PI_Q30 = 64'd1686629713;
  localparam longint      PHASE_GAIN = 41722;
  localparam longint      PHASE_HALF = 32768;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam longint      Q14_UNIT   = 16384;
  localparam longint      PROD_HALF  = 64'sd134217728;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam int          REPORT_MAX = 10;

  int                  quarter_sine [STEPS+1];
  ep2q_pkg::pose_out_t expected_poses [$];
  int                  errors = 0;
  int                  results_seen = 0;

  // Fill sin(k * (pi/2) / STEPS) in Q1.14 from a Q30 Taylor series
  initial begin : fill_sine
    u64_t   ang;
    u64_t   pow;
    longint acc;
    for (int k = 0; k <= int'(STEPS); k++) begin
      ang = (u64_t'(k) * HALF_PI_Q30) / STEPS;
      pow = ang;
      acc = longint'(ang);
      for (int n = 1; n <= 8; n++) begin
        pow = (pow * ang) >> 30;
        pow = ((pow * ang) >> 30) / u64_t'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(pow);
        end else begin
          acc = acc + longint'(pow);
        end
      end
      if (acc < 0) acc = 0;
      acc = (acc + 32768) >>> 16;
      quarter_sine[k] = (acc > Q14_UNIT) ? int'(Q14_UNIT) : int'(acc);
    end
  end

  // Half angle in 2^-16 turn: floor((a * 41722 + 32768) / 2^16) mod 2^16
  function automatic logic [15:0] half_turn_phase(logic signed [15:0] angle);
    longint t;
    t = longint'(angle) * PHASE_GAIN + PHASE_HALF;
    return t[31:16];
  endfunction

  // Quadrant-folded table lookup with index rounding
  function automatic longint table_sine(logic [15:0] phase);
    int unsigned idx;
    longint      v;
    idx = (int'(phase[13:0]) + IDX_ROUND) >> IDX_SHIFT;
    if (idx > STEPS) idx = STEPS;
    if (phase[14]) idx = STEPS - idx;
    v = quarter_sine[idx];
    return phase[15] ? -v : v;
  endfunction

  // Q3.42 sum to Q1.14, round half up, clamp to +-1.0
  function automatic logic signed [15:0] round_q14(longint s);
    longint r;
    r = (s + PROD_HALF) >>> 28;
    if (r > Q14_UNIT) r = Q14_UNIT;
    if (r < -Q14_UNIT) r = -Q14_UNIT;
    return 16'(r);
  endfunction

  function automatic ep2q_pkg::pose_out_t predict_frame_pose(ep2q_pkg::pose_in_t p);
    ep2q_pkg::pose_out_t f;
    logic [15:0]         ph_r, ph_p, ph_y;
    longint              sr, cr, sp, cp, sy, cy;
    ph_r = half_turn_phase(p.roll_angle);
    ph_p = half_turn_phase(p.pitch_angle);
    ph_y = half_turn_phase(p.yaw_angle);
    sr = table_sine(ph_r);
    cr = table_sine(ph_r + QUARTER_TURN);
    sp = table_sine(ph_p);
    cp = table_sine(ph_p + QUARTER_TURN);
    sy = table_sine(ph_y);
    cy = table_sine(ph_y + QUARTER_TURN);
    // NED to display axes; negated down saturates at the top of the range
    f.frame_x = p.pos_east;
    f.frame_y = p.pos_north;
    f.frame_z = (p.pos_down == POS_MIN) ? POS_MAX : -p.pos_down;
    f.quat_x  = round_q14(cy * sp * cr + sy * cp * sr);
    f.quat_y  = round_q14(cy * cp * sr - sy * sp * cr);
    f.quat_z  = round_q14(cy * sp * sr - sy * cp * cr);
    f.quat_w  = round_q14(cy * cp * cr + sy * sp * sr);
    return f;
  endfunction

  function automatic bit field_ok(string name, longint want, longint got);
    if (want == got) return 1'b1;
    if (errors < REPORT_MAX) begin
      $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
    end
    return 1'b0;
  endfunction

  // Check output transfers first, then record the new expectation
  always @(posedge clk_i) begin
    ep2q_pkg::pose_out_t want;
    bit                  ok;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_poses.size() == 0) begin
          if (errors < REPORT_MAX) begin
            $display("result %0d: unexpected output transfer", results_seen);
          end
          errors++;
        end else begin
          want = expected_poses.pop_front();
          ok = field_ok("frame_x", want.frame_x, out_data_i.frame_x)
             & field_ok("frame_y", want.frame_y, out_data_i.frame_y)
             & field_ok("frame_z", want.frame_z, out_data_i.frame_z)
             & field_ok("quat_x", want.quat_x, out_data_i.quat_x)
             & field_ok("quat_y", want.quat_y, out_data_i.quat_y)
             & field_ok("quat_z", want.quat_z, out_data_i.quat_z)
             & field_ok("quat_w", want.quat_w, out_data_i.quat_w);
          if (!ok) errors++;
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_poses.push_back(predict_frame_pose(in_data_i));
      end
    end
    pending_o    <= expected_poses.size();
    fail_count_o <= errors;
  end

endmodule

/* dv/euler_pose_to_quaternion_test.sv */
// ----------------------------------------------------------------------------
// euler_pose_to_quaternion_test: testbench top for the pose to quaternion block
// Drives directed edge poses, then random poses, with random idle cycles on
// both channels and one stretch at full rate. The checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module euler_pose_to_quaternion_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_POSES = 500;
  localparam int IDLE_PCT     = 29;
  localparam int CALM_FIRST   = 150;
  localparam int CALM_LAST    = 260;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 100000;

  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [15:0] ANG_MIN = 16'sh8000;
  localparam logic signed [15:0] ANG_MAX = 16'sh7FFF;
  localparam logic signed [15:0] ANG_HALF_PI = 16'sd12868;
  localparam logic signed [15:0] ANG_PI      = 16'sd25736;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ep2q_pkg::pose_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ep2q_pkg::pose_out_t out_data;
  int                  pending;
  int                  fail_count;
  int                  cycles = 0;
  bit                  calm = 1'b0;

  euler_pose_to_quaternion dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  pose_frame_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall at random except during the calm stretch
  always @(posedge clk_i) begin
    if (rst_n) begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic ep2q_pkg::pose_in_t mk_pose(
    logic signed [31:0] n, logic signed [31:0] e, logic signed [31:0] d,
    logic signed [15:0] r, logic signed [15:0] p, logic signed [15:0] y);
    ep2q_pkg::pose_in_t v;
    v.pos_north   = n;
    v.pos_east    = e;
    v.pos_down    = d;
    v.roll_angle  = r;
    v.pitch_angle = p;
    v.yaw_angle   = y;
    return v;
  endfunction

  // Mostly full-range positions, some at the edges
  function automatic logic signed [31:0] rand_position();
    unique case ($urandom_range(9))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return 32'($signed($urandom_range(15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Full-range angles, plus edges, small angles near zero and pi or -pi/2
  function automatic logic signed [15:0] rand_angle();
    unique case ($urandom_range(9))
      0: return ANG_MIN;
      1: return ANG_MAX;
      2: return 16'($signed($urandom_range(511)) - 256);
      3: return ($urandom_range(1) != 0) ? ANG_PI : -ANG_HALF_PI;
      default: return 16'($urandom);
    endcase
  endfunction

  // Hold valid and payload until the transfer, idling at random before it outside the calm stretch
  task automatic send_pose(input ep2q_pkg::pose_in_t p);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk_i); while (!in_ready);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed: position extremes, down saturation, angle extremes and axes
    send_pose(mk_pose(0, 0, 0, 0, 0, 0));
    send_pose(mk_pose(POS_MAX, POS_MIN, POS_MIN, 0, 0, 0));
    send_pose(mk_pose(POS_MIN, POS_MAX, POS_MAX, 0, 0, 0));
    send_pose(mk_pose(-1, 1, 1, 0, 0, 0));
    send_pose(mk_pose(1, -1, -1, 0, 0, 0));
    send_pose(mk_pose(0, 0, 0, ANG_MAX, 0, 0));
    send_pose(mk_pose(0, 0, 0, ANG_MIN, 0, 0));
    send_pose(mk_pose(0, 0, 0, 0, ANG_MAX, 0));
    send_pose(mk_pose(0, 0, 0, 0, ANG_MIN, 0));
    send_pose(mk_pose(0, 0, 0, 0, 0, ANG_MAX));
    send_pose(mk_pose(0, 0, 0, 0, 0, ANG_MIN));
    send_pose(mk_pose(7, 8, 9, ANG_HALF_PI, ANG_HALF_PI, ANG_HALF_PI));
    send_pose(mk_pose(7, 8, 9, ANG_PI, -ANG_PI, ANG_PI));
    send_pose(mk_pose(0, 0, 0, -1, -1, -1));
    send_pose(mk_pose(0, 0, 0, 1, 1, 1));
    send_pose(mk_pose(POS_MAX, POS_MAX, POS_MAX, ANG_MAX, ANG_MAX, ANG_MAX));
    send_pose(mk_pose(POS_MIN, POS_MIN, POS_MIN, ANG_MIN, ANG_MIN, ANG_MIN));
    send_pose(mk_pose(0, 0, 0, 0, ANG_HALF_PI, -ANG_HALF_PI));
    send_pose(mk_pose(0, 0, 0, 16'sd4096, 16'sd8192, -16'sd6434));
    send_pose(mk_pose(0, 0, 0, -ANG_HALF_PI, ANG_PI, 16'sd3217));

    // Random poses, with one stretch at full rate on both sides
    for (int i = 0; i < RANDOM_POSES; i++) begin
      calm = (i >= CALM_FIRST) && (i < CALM_LAST);
      send_pose(mk_pose(rand_position(), rand_position(), rand_position(),
                        rand_angle(), rand_angle(), rand_angle()));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain the pipeline, then watch for stray results
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
